>>> rtl/plcm_pkg.sv
// Shared types, widths and constants of the parallax layer coordinate mapper.
package plcm_pkg;

	localparam int CAM_W    = 21;
	localparam int OUT_W    = 23;
	localparam int LSIZE_W  = 16;
	localparam int MAG_W    = 40;
	localparam int DIG_W    = 4;
	localparam int MOD_STAGES = MAG_W / DIG_W;
	// six arithmetic stages, the remainder stages, one output stage
	localparam int AXIS_LAT = 7 + MOD_STAGES;

	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAP_REPEATING = 3'd2;
	localparam logic [IDX_W-1:0] REG_BOUND_LEFT    = 3'd3;
	localparam logic [IDX_W-1:0] REG_BOUND_TOP     = 3'd4;
	localparam logic [IDX_W-1:0] REG_BOUND_RIGHT   = 3'd5;
	localparam logic [IDX_W-1:0] REG_BOUND_BOTTOM  = 3'd6;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 23'sd4194303;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -23'sd4194304;

	typedef struct packed {
		logic                    wrap;
		logic                    neg;
		logic signed [OUT_W-1:0] sat_v;
	} plcm_side_t;

	// Four restoring remainder steps, most significant digit bit first.
	function automatic logic [LSIZE_W-1:0] mod_digits(input logic [LSIZE_W-1:0] r,
		input logic [DIG_W-1:0] d, input logic [LSIZE_W-1:0] l);
		logic [LSIZE_W:0]   t;
		logic [LSIZE_W-1:0] acc;
		acc = r;
		for (int i = DIG_W - 1; i >= 0; i--) begin
			t = {acc, d[i]};
			if (t >= {1'b0, l}) begin
				t = t - {1'b0, l};
			end
			acc = t[LSIZE_W-1:0];
		end
		return acc;
	endfunction

endpackage

>>> rtl/plcm_mod.sv
// Pipelined remainder unit: magnitude modulo layer size, four bits a stage.
module plcm_mod (
	input  logic                            clk,
	input  logic [plcm_pkg::MAG_W-1:0]      mag,
	input  logic [plcm_pkg::LSIZE_W-1:0]    lsize,
	input  plcm_pkg::plcm_side_t            side_in,
	output logic [plcm_pkg::LSIZE_W-1:0]    rem,
	output logic [plcm_pkg::LSIZE_W-1:0]    lsize_out,
	output plcm_pkg::plcm_side_t            side_out
);

	logic [plcm_pkg::LSIZE_W-1:0] rem_s   [plcm_pkg::MOD_STAGES+1];
	logic [plcm_pkg::MAG_W-1:0]   mag_s   [plcm_pkg::MOD_STAGES+1];
	logic [plcm_pkg::LSIZE_W-1:0] lsize_s [plcm_pkg::MOD_STAGES+1];
	plcm_pkg::plcm_side_t         side_s  [plcm_pkg::MOD_STAGES+1];

	assign rem_s[0]   = '0;
	assign mag_s[0]   = mag;
	assign lsize_s[0] = lsize;
	assign side_s[0]  = side_in;

	for (genvar g = 0; g < plcm_pkg::MOD_STAGES; g++) begin : g_stage
		always_ff @(posedge clk) begin
			rem_s[g+1]   <= plcm_pkg::mod_digits(rem_s[g],
				mag_s[g][plcm_pkg::MAG_W-1-plcm_pkg::DIG_W*g -: plcm_pkg::DIG_W], lsize_s[g]);
			mag_s[g+1]   <= mag_s[g];
			lsize_s[g+1] <= lsize_s[g];
			side_s[g+1]  <= side_s[g];
		end
	end

	assign rem       = rem_s[plcm_pkg::MOD_STAGES];
	assign lsize_out = lsize_s[plcm_pkg::MOD_STAGES];
	assign side_out  = side_s[plcm_pkg::MOD_STAGES];

endmodule

>>> rtl/plcm_axis.sv
// One axis of the mapper: clamp, offset arithmetic, wrap and saturation.
module plcm_axis (
	input  logic                                clk,
	input  logic signed [plcm_pkg::CAM_W-1:0]   cam,
	input  logic signed [plcm_pkg::CAM_W-1:0]   pt,
	input  logic [23:0]                         frames,
	input  logic signed [15:0]                  rate,
	input  logic signed [15:0]                  factor,
	input  logic [12:0]                         screen,
	input  logic signed [plcm_pkg::CAM_W-1:0]   lo_bound,
	input  logic signed [plcm_pkg::CAM_W-1:0]   hi_bound,
	input  logic [plcm_pkg::LSIZE_W-1:0]        layer_size,
	input  logic                                repeating,
	input  logic                                parallax,
	output logic signed [plcm_pkg::OUT_W-1:0]   res
);

	logic [11:0]        centre;
	logic signed [22:0] lo_c, hi_c, cam_c;
	logic               zoff_c;

	assign centre = screen[12:1];

	// clamp the camera inside the bounds when the map does not repeat, lower limit first
	always_comb begin
		lo_c  = 23'(lo_bound) + signed'({11'b0, centre});
		hi_c  = 23'(hi_bound) - signed'({11'b0, centre});
		cam_c = 23'(cam);
		if (!repeating) begin
			if (cam_c < lo_c) begin
				cam_c = lo_c;
			end
			if (cam_c > hi_c) begin
				cam_c = hi_c;
			end
		end
		zoff_c = !repeating && !parallax && ({1'b0, layer_size} < {4'b0, screen});
	end

	logic signed [22:0]          cam_s1;
	logic [11:0]                 centre_s1;
	logic signed [20:0]          pt_s1, pt_s2, pt_s3, pt_s4;
	logic [23:0]                 frames_s1;
	logic signed [15:0]          rate_s1, factor_s1;
	logic [15:0]                 lsize_s1, lsize_s2, lsize_s3, lsize_s4, lsize_s5, lsize_s6;
	logic                        wrap_s1, wrap_s2, wrap_s3, wrap_s4, wrap_s5;
	logic                        zoff_s1, zoff_s2, zoff_s3;

	always_ff @(posedge clk) begin
		cam_s1    <= cam_c;
		centre_s1 <= centre;
		pt_s1     <= pt;
		frames_s1 <= frames;
		rate_s1   <= rate;
		factor_s1 <= factor;
		lsize_s1  <= layer_size;
		wrap_s1   <= repeating || parallax;
		zoff_s1   <= zoff_c;
	end

	logic signed [16:0] fac_m;
	logic signed [40:0] fs_s2;
	logic signed [39:0] cp_s2;
	logic signed [23:0] diff_s2;

	assign fac_m = 17'(factor_s1) - 17'sd256;

	always_ff @(posedge clk) begin
		fs_s2    <= signed'({1'b0, frames_s1}) * rate_s1;
		cp_s2    <= cam_s1 * fac_m;
		diff_s2  <= 24'(cam_s1) - signed'({12'b0, centre_s1});
		pt_s2    <= pt_s1;
		lsize_s2 <= lsize_s1;
		wrap_s2  <= wrap_s1;
		zoff_s2  <= zoff_s1;
	end

	logic signed [43:0] num_s3;

	always_ff @(posedge clk) begin
		num_s3   <= (44'(diff_s2) <<< 8) - (44'(fs_s2) - 44'(cp_s2));
		pt_s3    <= pt_s2;
		lsize_s3 <= lsize_s2;
		wrap_s3  <= wrap_s2;
		zoff_s3  <= zoff_s2;
	end

	// truncate toward zero: bias negative numerators before the shift
	logic signed [43:0] numr;
	logic signed [35:0] off_s4;

	assign numr = num_s3 + (num_s3[43] ? 44'sd255 : 44'sd0);

	always_ff @(posedge clk) begin
		off_s4   <= zoff_s3 ? '0 : signed'(numr[43:8]);
		pt_s4    <= pt_s3;
		lsize_s4 <= lsize_s3;
		wrap_s4  <= wrap_s3;
	end

	logic signed [37:0] v_s5;

	always_ff @(posedge clk) begin
		v_s5     <= 38'(pt_s4) + 38'(off_s4);
		lsize_s5 <= lsize_s4;
		wrap_s5  <= wrap_s4;
	end

	logic [37:0]                   mag_c;
	logic signed [plcm_pkg::OUT_W-1:0] sat_c;
	logic [plcm_pkg::MAG_W-1:0]    mag_s6;
	plcm_pkg::plcm_side_t          side_s6;

	always_comb begin
		mag_c = v_s5[37] ? 38'(-v_s5) : 38'(v_s5);
		if (v_s5 > 38'(plcm_pkg::OUT_MAX)) begin
			sat_c = plcm_pkg::OUT_MAX;
		end else if (v_s5 < 38'(plcm_pkg::OUT_MIN)) begin
			sat_c = plcm_pkg::OUT_MIN;
		end else begin
			sat_c = v_s5[plcm_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		mag_s6        <= plcm_pkg::MAG_W'(mag_c);
		side_s6.wrap  <= wrap_s5;
		side_s6.neg   <= v_s5[37];
		side_s6.sat_v <= sat_c;
		lsize_s6      <= lsize_s5;
	end

	logic [15:0]          rem_m, lsize_m;
	plcm_pkg::plcm_side_t side_m;

	plcm_mod u_mod (
		.clk       (clk),
		.mag       (mag_s6),
		.lsize     (lsize_s6),
		.side_in   (side_s6),
		.rem       (rem_m),
		.lsize_out (lsize_m),
		.side_out  (side_m)
	);

	// floor modulo: fold a negative remainder back into the layer; an axis that does not wrap gives its saturated value
	always_ff @(posedge clk) begin
		if (!side_m.wrap) begin
			res <= side_m.sat_v;
		end else if (lsize_m == '0) begin
			res <= '0;
		end else if (side_m.neg && (rem_m != '0)) begin
			res <= signed'({7'b0, lsize_m - rem_m});
		end else begin
			res <= signed'({7'b0, rem_m});
		end
	end

endmodule

>>> rtl/parallax_layer_coordinate_mapper.sv
// Top level of the parallax layer coordinate mapper: config registers and beat valids.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  command  | camera_pos_*, point_*, frame_count, ... | start & !busy
//  result   | layer_x, layer_y                        | done, one cycle, no hold
//  config   | cfg_wr_en, cfg_idx, cfg_wdata           | cfg_wr_en, no wait
//
// A beat may enter every cycle; busy is always low.
// Each result passes through the AXIS_LAT stages after its command: six arithmetic stages,
// ten remainder stages at four bits each, one output stage.
// Reset clears the config registers to their defaults and drops every beat in flight.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module parallax_layer_coordinate_mapper (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [20:0]                  camera_pos_x,
	input  logic signed [20:0]                  camera_pos_y,
	input  logic signed [20:0]                  point_x,
	input  logic signed [20:0]                  point_y,
	input  logic [23:0]                         frame_count,
	input  logic [15:0]                         layer_width_px,
	input  logic [15:0]                         layer_height_px,
	input  logic signed [15:0]                  parallax_factor_x,
	input  logic signed [15:0]                  parallax_factor_y,
	input  logic signed [15:0]                  scroll_rate_x,
	input  logic signed [15:0]                  scroll_rate_y,
	input  logic                                layer_parallax,
	output logic                                done,
	output logic signed [22:0]                  layer_x,
	output logic signed [22:0]                  layer_y,
	input  logic                                cfg_wr_en,
	input  logic [plcm_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [20:0]                         cfg_wdata
);

	logic [12:0]        screen_width_q, screen_height_q;
	logic               map_repeating_q;
	logic signed [20:0] bound_left_q, bound_top_q, bound_right_q, bound_bottom_q;

	// register file: write on enable, ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 13'd320;
			screen_height_q <= 13'd240;
			map_repeating_q <= 1'b0;
			bound_left_q    <= 21'sd0;
			bound_top_q     <= 21'sd0;
			bound_right_q   <= 21'sd320;
			bound_bottom_q  <= 21'sd240;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				plcm_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata[12:0];
				plcm_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata[12:0];
				plcm_pkg::REG_MAP_REPEATING: map_repeating_q <= cfg_wdata[0];
				plcm_pkg::REG_BOUND_LEFT:    bound_left_q    <= cfg_wdata;
				plcm_pkg::REG_BOUND_TOP:     bound_top_q     <= cfg_wdata;
				plcm_pkg::REG_BOUND_RIGHT:   bound_right_q   <= cfg_wdata;
				plcm_pkg::REG_BOUND_BOTTOM:  bound_bottom_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// the pipeline takes a beat every cycle
	assign busy = 1'b0;

	logic [plcm_pkg::AXIS_LAT-1:0] vld_q;

	// advance the beat valids alongside the axis pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[plcm_pkg::AXIS_LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[plcm_pkg::AXIS_LAT-1];

	plcm_axis u_axis_x (
		.clk        (clk),
		.cam        (camera_pos_x),
		.pt         (point_x),
		.frames     (frame_count),
		.rate       (scroll_rate_x),
		.factor     (parallax_factor_x),
		.screen     (screen_width_q),
		.lo_bound   (bound_left_q),
		.hi_bound   (bound_right_q),
		.layer_size (layer_width_px),
		.repeating  (map_repeating_q),
		.parallax   (layer_parallax),
		.res        (layer_x)
	);

	plcm_axis u_axis_y (
		.clk        (clk),
		.cam        (camera_pos_y),
		.pt         (point_y),
		.frames     (frame_count),
		.rate       (scroll_rate_y),
		.factor     (parallax_factor_y),
		.screen     (screen_height_q),
		.lo_bound   (bound_top_q),
		.hi_bound   (bound_bottom_q),
		.layer_size (layer_height_px),
		.repeating  (map_repeating_q),
		.parallax   (layer_parallax),
		.res        (layer_y)
	);

	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, plcm_pkg::AXIS_LAT))
		else $error("result beat without a command");

	a_no_cmd_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, plcm_pkg::AXIS_LAT) |-> !done)
		else $error("result beat appeared without its command");

	a_first_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> !vld_q[0])
		else $error("first stage valid set without a command");

endmodule
